### sv/vrs_pkg.sv
// Shared types and constants of the 3D voxel ray stepper.
package vrs_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int OUT_BITS           = 16;

   typedef enum logic {
      ACTION_START   = 1'b0,
      ACTION_ADVANCE = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_VOXEL  = 2'd0,
      STATUS_EMPTY  = 2'd1,
      STATUS_NO_RAY = 2'd2
   } status_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] voxel_z;
      logic [OUT_BITS-1:0] voxel_y;
      logic [OUT_BITS-1:0] voxel_x;
      logic                reached_end;
      status_type          status;
   } result_type;

endpackage

### sv/vrs_pick.sv
// Three-way minimum selector: flags every enabled axis whose key is the smallest.
module vrs_pick #(
   parameter int W = 16
) (
   input  logic [2:0][W-1:0] key,
   input  logic [2:0]        en,
   output logic [2:0]        sel
);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sel[i] = en[i];
         for (int j = 0; j < 3; j++) begin
            if (j != i && en[j] && (key[i] > key[j])) begin
               sel[i] = 1'b0;
            end
         end
      end
   end

endmodule

### sv/vrs_intake.sv
// Input register of the ray stepper: captures a transaction and its per-axis deltas.
module vrs_intake #(
   parameter int COORD_BITS = vrs_pkg::COORD_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  vrs_pkg::action_type               req_action,
   input  logic [2:0][vrs_pkg::OUT_BITS-1:0] req_start,
   input  logic [2:0][vrs_pkg::OUT_BITS-1:0] req_end,
   input  logic                              take,
   output logic                              s_valid,
   output vrs_pkg::action_type               s_action,
   output logic [2:0][COORD_BITS-1:0]        s_start,
   output logic [2:0][COORD_BITS-1:0]        s_end,
   output logic [2:0]                        s_neg,
   output logic [2:0][COORD_BITS-1:0]        s_delta
);

   localparam int CB = COORD_BITS;

   logic                        valid_ff, valid_in;
   vrs_pkg::action_type         action_ff;
   logic [2:0][CB-1:0]          start_ff, end_ff, delta_ff;
   logic [2:0][CB-1:0]          start_in, end_in, delta_in;
   logic [2:0]                  neg_ff, neg_in;
   logic [2:0][CB:0]            s_ext, e_ext;
   logic                        accept;

   assign req_ready = !valid_ff || take;
   assign accept    = req_valid && req_ready;

   // Coordinates are the low COORD_BITS of the field, as two's complement.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         start_in[i] = CB'({{CB{1'b0}}, req_start[i]});
         end_in[i]   = CB'({{CB{1'b0}}, req_end[i]});
         s_ext[i]    = {start_in[i][CB-1], start_in[i]};
         e_ext[i]    = {end_in[i][CB-1], end_in[i]};
         neg_in[i]   = $signed(s_ext[i]) > $signed(e_ext[i]);
         delta_in[i] = neg_in[i] ? CB'(s_ext[i] - e_ext[i]) : CB'(e_ext[i] - s_ext[i]);
      end
      valid_in = accept ? 1'b1 : (take ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         start_ff  <= start_in;
         end_ff    <= end_in;
         neg_ff    <= neg_in;
         delta_ff  <= delta_in;
      end
   end

   assign s_valid  = valid_ff;
   assign s_action = action_ff;
   assign s_start  = start_ff;
   assign s_end    = end_ff;
   assign s_neg    = neg_ff;
   assign s_delta  = delta_ff;

endmodule

### sv/vrs_core.sv
// Ray state, crossing accumulators, voxel step and result register.
module vrs_core #(
   parameter int COORD_BITS = vrs_pkg::COORD_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       take,
   output logic                       ready,
   input  vrs_pkg::action_type        s_action,
   input  logic [2:0][COORD_BITS-1:0] s_start,
   input  logic [2:0][COORD_BITS-1:0] s_end,
   input  logic [2:0]                 s_neg,
   input  logic [2:0][COORD_BITS-1:0] s_delta,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output vrs_pkg::result_type        rsp_result
);

   localparam int CB  = COORD_BITS;
   localparam int PW  = 2*COORD_BITS;
   localparam int IW  = 2*COORD_BITS + 1;
   localparam int NCW = 3*COORD_BITS + 2;
   localparam int OB  = vrs_pkg::OUT_BITS;

   logic [2:0][CB-1:0]  cur_ff, cur_in, end_ff, end_in;
   logic [2:0]          neg_ff, neg_in, moves_ff, moves_in;
   logic [2:0][NCW-1:0] nc_ff, nc_in;
   logic [2:0][IW-1:0]  inc_ff, inc_in;
   logic                active_ff, active_in;
   logic                rsp_valid_ff, rsp_valid_in;
   vrs_pkg::result_type rsp_ff, rsp_in;

   logic [2:0][CB-1:0]  factor, inv_delta, base, stepped;
   logic [2:0][PW-1:0]  prod;
   logic [2:0]          start_moves, pick_start, pick_walk, step;
   logic                is_start, done;

   assign ready    = !rsp_valid_ff || rsp_ready;
   assign is_start = (s_action == vrs_pkg::ACTION_START);

   // Product of the other axes' nonzero deltas for each axis.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         factor[i]      = (s_delta[i] == '0) ? CB'(1) : s_delta[i];
         inv_delta[i]   = ~s_delta[i];
         start_moves[i] = (s_delta[i] != '0);
      end
      prod[0] = PW'(factor[1]) * PW'(factor[2]);
      prod[1] = PW'(factor[0]) * PW'(factor[2]);
      prod[2] = PW'(factor[0]) * PW'(factor[1]);
   end

   // First crossing is the smallest product, i.e. the largest delta.
   vrs_pick #(.W(CB)) u_pick_start (
      .key (inv_delta),
      .en  (start_moves),
      .sel (pick_start)
   );

   vrs_pick #(.W(NCW)) u_pick_walk (
      .key (nc_ff),
      .en  (moves_ff),
      .sel (pick_walk)
   );

   always_comb begin
      cur_in    = cur_ff;
      end_in    = end_ff;
      neg_in    = neg_ff;
      moves_in  = moves_ff;
      nc_in     = nc_ff;
      inc_in    = inc_ff;
      active_in = active_ff;
      rsp_in    = rsp_ff;

      step = is_start ? pick_start : pick_walk;
      for (int i = 0; i < 3; i++) begin
         base[i]    = is_start ? s_start[i] : cur_ff[i];
         stepped[i] = step[i] ? ((is_start ? s_neg[i] : neg_ff[i]) ? base[i] - CB'(1)
                                                                    : base[i] + CB'(1))
                              : base[i];
      end
      done = is_start ? (stepped == s_end) : (stepped == end_ff);

      if (take) begin
         if (is_start) begin
            end_in   = s_end;
            neg_in   = s_neg;
            moves_in = start_moves;
            for (int i = 0; i < 3; i++) begin
               if (start_moves[i]) begin
                  inc_in[i] = {prod[i], 1'b0};
                  nc_in[i]  = step[i] ? NCW'(prod[i]) + NCW'({prod[i], 1'b0})
                                      : NCW'(prod[i]);
               end else begin
                  inc_in[i] = '0;
                  nc_in[i]  = '0;
               end
            end
            if (start_moves == 3'b000) begin
               cur_in    = s_start;
               active_in = 1'b0;
               rsp_in.reached_end = 1'b0;
               rsp_in.status      = vrs_pkg::STATUS_EMPTY;
            end else begin
               cur_in    = stepped;
               active_in = !done;
               rsp_in.reached_end = done;
               rsp_in.status      = vrs_pkg::STATUS_VOXEL;
            end
            rsp_in.voxel_x = OB'({{OB{1'b0}}, cur_in[0]});
            rsp_in.voxel_y = OB'({{OB{1'b0}}, cur_in[1]});
            rsp_in.voxel_z = OB'({{OB{1'b0}}, cur_in[2]});
         end else if (!active_ff) begin
            rsp_in.voxel_x     = '0;
            rsp_in.voxel_y     = '0;
            rsp_in.voxel_z     = '0;
            rsp_in.reached_end = 1'b0;
            rsp_in.status      = vrs_pkg::STATUS_NO_RAY;
         end else begin
            cur_in = stepped;
            for (int i = 0; i < 3; i++) begin
               if (step[i]) begin
                  nc_in[i] = nc_ff[i] + NCW'(inc_ff[i]);
               end
            end
            active_in          = !done;
            rsp_in.voxel_x     = OB'({{OB{1'b0}}, stepped[0]});
            rsp_in.voxel_y     = OB'({{OB{1'b0}}, stepped[1]});
            rsp_in.voxel_z     = OB'({{OB{1'b0}}, stepped[2]});
            rsp_in.reached_end = done;
            rsp_in.status      = vrs_pkg::STATUS_VOXEL;
         end
      end

      rsp_valid_in = take ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         moves_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         moves_ff     <= moves_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      end_ff <= end_in;
      neg_ff <= neg_in;
      nc_ff  <= nc_in;
      inc_ff <= inc_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule

### sv/voxel_ray_stepper_3d_top.sv
// Top level of the 3D voxel ray stepper: stream ports, input register and stepping core.
//
// Walks the integer voxels on a 3D line. A start transaction (req_tuser = 0) loads a ray
// from the start to the end point and answers with the first voxel stepped to; every
// advance transaction (req_tuser = 1) answers with the next voxel. Per axis the next
// boundary crossing is kept as an exact integer, (2k+1) times the product of the other
// axes' nonzero deltas; the axis with the smallest crossing steps, and on a tie all tied
// axes step together. rsp_tlast marks the end voxel, after which the ray is finished.
// rsp_tuser gives the status: 0 voxel valid, 1 empty ray (start equals end; voxel is the
// start point), 2 no active ray (voxel zero). A start always drops any ray in progress;
// to stop early, simply stop advancing. Every request gives exactly one response.
// Throughput is one transaction per clock while responses are taken. A request sits
// in the input register until the core takes it, then moves into the result register,
// from which its response is offered. The rate is set by the per-voxel loop of crossing
// compare, accumulate and end check on the ray state registers. While a response waits
// to be taken the input register still accepts one more request; after that req_tready
// stays low until the waiting response goes.
module voxel_ray_stepper_3d_top #(
   parameter int COORD_BITS = vrs_pkg::COORD_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // start_x, start_y, start_z, end_x, end_y, end_z
   input  logic        req_tuser,  // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // voxel_x, voxel_y, voxel_z
   output logic        rsp_tlast,  // reached_end
   output logic [1:0]  rsp_tuser   // status
);

   localparam int OB = vrs_pkg::OUT_BITS;

   logic [2:0][OB-1:0]         req_start, req_end;
   logic [2:0][COORD_BITS-1:0] s_start, s_end, s_delta;
   logic [2:0]                 s_neg;
   logic                       s_valid, core_ready, take;
   vrs_pkg::action_type        s_action;
   vrs_pkg::result_type        result;

   // Unpack the request transaction into per-axis coordinates.
   assign req_start = req_tdata[3*OB-1:0];
   assign req_end   = req_tdata[6*OB-1:3*OB];

   // Advance the input register into the core whenever the response slot is free.
   assign take = s_valid && core_ready;

   vrs_intake #(.COORD_BITS(COORD_BITS)) u_intake (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (vrs_pkg::action_type'(req_tuser)),
      .req_start  (req_start),
      .req_end    (req_end),
      .take       (take),
      .s_valid    (s_valid),
      .s_action   (s_action),
      .s_start    (s_start),
      .s_end      (s_end),
      .s_neg      (s_neg),
      .s_delta    (s_delta)
   );

   vrs_core #(.COORD_BITS(COORD_BITS)) u_core (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .ready      (core_ready),
      .s_action   (s_action),
      .s_start    (s_start),
      .s_end      (s_end),
      .s_neg      (s_neg),
      .s_delta    (s_delta),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   // Pack the response transaction.
   assign rsp_tdata = {result.voxel_z, result.voxel_y, result.voxel_x};
   assign rsp_tlast = result.reached_end;
   assign rsp_tuser = result.status;

endmodule

### sv/vrs_checker.sv
// Port-level checks of the voxel ray stepper, bound to the top level.
module vrs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [1:0]  rsp_tuser
);

   // A response is never valid right after reset is released.
   a_quiet_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // An empty ray never marks an end voxel.
   a_empty_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == vrs_pkg::STATUS_EMPTY) |-> !rsp_tlast)
      else $error("empty ray response flagged as last");

   // No active ray: voxel and end flag are zero.
   a_no_ray_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == vrs_pkg::STATUS_NO_RAY) |-> (rsp_tdata == '0) && !rsp_tlast)
      else $error("no-ray response carries data");

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

endmodule

bind voxel_ray_stepper_3d_top vrs_checker u_vrs_checker (.*);
